// ===== src/lsb_stego_embed_unit_assert.svh =====
// Assertion macros shared by the LSB embedding unit.
// Each macro expands to one labelled concurrent assertion clocked on i_clk.
`ifndef LSB_STEGO_EMBED_UNIT_ASSERT_SVH
`define LSB_STEGO_EMBED_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lse assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is held.
`define LSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lse assertion failed: next-cycle check");

`endif

// ===== src/lse_pkg.sv =====
// Package for the LSB embedding unit: operation and result codes, control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lse_pkg;

    typedef enum logic [1:0] {
        OP_COVER   = 2'd0,
        OP_MESSAGE = 2'd1,
        OP_END     = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_STEGO    = 2'd0,
        KIND_UNDERRUN = 2'd1,
        KIND_DROPPED  = 2'd2
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_res_ctrl;

    localparam logic [3:0] BITS_MIN   = 4'd1;
    localparam logic [3:0] BITS_MAX   = 4'd8;
    localparam logic [3:0] BITS_RESET = 4'd1;

    // Out-of-range settings saturate to the legal span of one to eight bits.
    function automatic logic [3:0] clamp_bits(input logic [3:0] raw);
        logic [3:0] n;
        n = raw;
        if (raw < BITS_MIN) begin
            n = BITS_MIN;
        end else if (raw > BITS_MAX) begin
            n = BITS_MAX;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== src/lse_core.sv =====
// Combinational next-state and result logic of the LSB embedding unit.
// Depends on lse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lse_core #(
    parameter  int BUF_BITS = 16,
    localparam int CW       = $clog2(BUF_BITS + 1)
) (
    input  wire logic [1:0]          i_op,
    input  wire logic [7:0]          i_byte,
    input  wire logic [3:0]          i_bits_raw,
    input  wire logic [BUF_BITS-1:0] i_buf,
    input  wire logic [CW-1:0]       i_count,
    input  wire logic                i_ended,
    output lse_pkg::t_res_ctrl       o_res,
    output logic      [7:0]          o_byte,
    output logic      [BUF_BITS-1:0] o_buf,
    output logic      [CW-1:0]       o_count,
    output logic                     o_ended
);

    logic [3:0]          n;
    logic [7:0]          mask;
    logic                have;
    logic [CW-1:0]       rem;
    logic [BUF_BITS-1:0] shifted;
    logic [BUF_BITS-1:0] kept;
    logic [7:0]          chunk_full;
    logic [7:0]          chunk_pad;
    logic                fits;

    assign n          = lse_pkg::clamp_bits(i_bits_raw);
    assign mask       = 8'((9'd1 << n) - 9'd1);
    assign have       = i_count >= CW'(n);
    assign rem        = i_count - CW'(n);
    assign shifted    = i_buf >> rem;
    assign chunk_full = shifted[7:0] & mask;
    assign kept       = i_buf & ~({BUF_BITS{1'b1}} << rem);
    // Fewer than n bits remain here, so the count fits in four bits.
    assign chunk_pad  = 8'(i_buf[7:0] << (n - i_count[3:0])) & mask;
    assign fits       = ({1'b0, i_count} + (CW+1)'(8)) <= (CW+1)'(BUF_BITS);

    always_comb begin
        o_res   = '{valid: 1'b0, kind: lse_pkg::KIND_STEGO};
        o_byte  = i_byte;
        o_buf   = i_buf;
        o_count = i_count;
        o_ended = i_ended;
        case (i_op)
            lse_pkg::OP_MESSAGE: begin
                if (i_ended || !fits) begin
                    o_res = '{valid: 1'b1, kind: lse_pkg::KIND_DROPPED};
                end else begin
                    o_buf   = {i_buf[BUF_BITS-9:0], i_byte};
                    o_count = i_count + CW'(8);
                end
            end
            lse_pkg::OP_END: begin
                o_ended = 1'b1;
            end
            lse_pkg::OP_COVER: begin
                o_res.valid = 1'b1;
                if (have) begin
                    o_byte  = (i_byte & ~mask) | chunk_full;
                    o_buf   = kept;
                    o_count = rem;
                end else if (!i_ended) begin
                    o_res.kind = lse_pkg::KIND_UNDERRUN;
                end else if (i_count != '0) begin
                    // Final partial chunk, zero padded in its low bits.
                    o_byte  = (i_byte & ~mask) | chunk_pad;
                    o_buf   = '0;
                    o_count = '0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/lsb_stego_embed_unit.sv =====
// A result beat is registered and appears in the cycle after the input beat that causes it.
// Throughput: one input beat per cycle; the output register is refilled in the
// same cycle it is taken, so input only stalls while a result waits unaccepted.
// Reset (synchronous, active low) empties the message buffer, reopens the
// message and sets bits_per_byte to one.
// Top level of the LSB embedding unit; depends on lse_pkg, lse_core and the assert header.
`timescale 1ns / 1ps
`default_nettype none
`include "lsb_stego_embed_unit_assert.svh"

module lsb_stego_embed_unit #(
    parameter int MESSAGE_BUFFER_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [3:0] i_cfg_wr_data,   // bits_per_byte
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,    // [7:0] data_byte
    input  wire logic [1:0] s_axis_tuser,    // [1:0] operation
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic      [7:0] m_axis_tdata,    // [7:0] out_byte
    output logic      [1:0] m_axis_tuser     // [1:0] result_kind
);

    localparam int CW = $clog2(MESSAGE_BUFFER_BITS + 1);

    logic [3:0]                     r_bits;
    logic [MESSAGE_BUFFER_BITS-1:0] r_buf;
    logic [CW-1:0]                  r_count;
    logic                           r_ended;
    logic                           r_out_valid;
    lse_pkg::t_kind                 r_out_kind;
    logic [7:0]                     r_out_byte;

    lse_pkg::t_res_ctrl             n_res;
    logic [7:0]                     n_byte;
    logic [MESSAGE_BUFFER_BITS-1:0] n_buf;
    logic [CW-1:0]                  n_count;
    logic                           n_ended;
    logic                           accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_kind;

    lse_core #(
        .BUF_BITS(MESSAGE_BUFFER_BITS)
    ) u_core (
        .i_op      (s_axis_tuser),
        .i_byte    (s_axis_tdata),
        .i_bits_raw(r_bits),
        .i_buf     (r_buf),
        .i_count   (r_count),
        .i_ended   (r_ended),
        .o_res     (n_res),
        .o_byte    (n_byte),
        .o_buf     (n_buf),
        .o_count   (n_count),
        .o_ended   (n_ended)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits      <= lse_pkg::BITS_RESET;
            r_buf       <= '0;
            r_count     <= '0;
            r_ended     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_bits <= i_cfg_wr_data;
            end
            if (accept) begin
                r_buf       <= n_buf;
                r_count     <= n_count;
                r_ended     <= n_ended;
                r_out_valid <= n_res.valid;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_res.valid) begin
            r_out_kind <= n_res.kind;
            r_out_byte <= n_byte;
        end
    end

    `LSE_ASSERT_NOW(a_count_in_range, 1'b1, r_count <= CW'(MESSAGE_BUFFER_BITS))
    `LSE_ASSERT_NOW(a_ready_when_empty, !r_out_valid, s_axis_tready)
    `LSE_ASSERT_NOW(a_underrun_only_open, r_out_valid && r_out_kind == lse_pkg::KIND_UNDERRUN, !r_ended)
    `LSE_ASSERT_NEXT(a_end_sticks, accept && s_axis_tuser == lse_pkg::OP_END, r_ended)
    `LSE_ASSERT_NEXT(a_msg_grows, accept && s_axis_tuser == lse_pkg::OP_MESSAGE && !n_res.valid, r_count == $past(r_count) + CW'(8))

endmodule

`default_nettype wire

// ===== tb/sv/tb_lsb_stego_embed_unit.sv =====
// Self-checking testbench for lsb_stego_embed_unit: directed and random beats,
// predicted by a scoreboard class that tracks the message bit buffer.
// Depends on lse_pkg and the lsb_stego_embed_unit RTL.
`timescale 1ns / 1ps

module tb_lsb_stego_embed_unit;

    localparam int BUF_BITS        = 16;
    localparam int IDLE_LIMIT      = 1000;
    localparam int HOLD_CYCLES     = 64;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int NUM_PHASES      = 12;
    localparam int SETTLE_CYCLES   = 4;

    // The one operation code with no meaning; the block must ignore it.
    localparam logic [1:0] OP_RESERVED = 2'd3;

    class stego_scoreboard;
        logic [3:0]     bits_reg;
        logic [15:0]    msg_bits;
        logic [4:0]     msg_count;
        bit             msg_ended;
        lse_pkg::t_kind want_kind[$];
        logic [7:0]     want_byte[$];
        int             errors;
        int             inputs_seen;
        int             results_seen;

        function new();
            bits_reg     = lse_pkg::BITS_RESET;
            msg_bits     = '0;
            msg_count    = '0;
            msg_ended    = 1'b0;
            errors       = 0;
            inputs_seen  = 0;
            results_seen = 0;
        endfunction

        function void set_bits(logic [3:0] value);
            bits_reg = value;
        endfunction

        // Settings outside one to eight saturate at the nearer limit.
        function logic [3:0] eff_bits();
            logic [3:0] n;
            n = bits_reg;
            if (n == 4'd0) begin
                n = 4'd1;
            end else if (n > 4'd8) begin
                n = 4'd8;
            end
            return n;
        endfunction

        function int pending();
            return want_kind.size();
        endfunction

        function void add_expected(lse_pkg::t_kind kind, logic [7:0] value);
            want_kind.push_back(kind);
            want_byte.push_back(value);
        endfunction

        function void note_input(logic [1:0] op, logic [7:0] data);
            logic [3:0] n;
            logic [7:0] mask;
            logic [7:0] chunk;
            inputs_seen++;
            n    = eff_bits();
            mask = 8'((9'd1 << n) - 9'd1);
            case (op)
                lse_pkg::OP_MESSAGE: begin
                    if (msg_ended || msg_count > 5'(BUF_BITS - 8)) begin
                        add_expected(lse_pkg::KIND_DROPPED, data);
                    end else begin
                        msg_bits  = {msg_bits[7:0], data};
                        msg_count = msg_count + 5'd8;
                    end
                end
                lse_pkg::OP_END: begin
                    msg_ended = 1'b1;
                end
                lse_pkg::OP_COVER: begin
                    if (msg_count >= n) begin
                        // Oldest bits sit at the top of the valid part of the buffer.
                        chunk     = 8'(msg_bits >> (msg_count - n)) & mask;
                        msg_count = msg_count - n;
                        msg_bits  = msg_bits & 16'((17'd1 << msg_count) - 17'd1);
                        add_expected(lse_pkg::KIND_STEGO, (data & ~mask) | chunk);
                    end else if (!msg_ended) begin
                        add_expected(lse_pkg::KIND_UNDERRUN, data);
                    end else if (msg_count != 0) begin
                        // Final partial chunk, zero padded below.
                        chunk     = 8'(msg_bits << (n - msg_count)) & mask;
                        msg_count = '0;
                        msg_bits  = '0;
                        add_expected(lse_pkg::KIND_STEGO, (data & ~mask) | chunk);
                    end else begin
                        add_expected(lse_pkg::KIND_STEGO, data);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] value);
            lse_pkg::t_kind exp_kind;
            logic [7:0]     exp_byte;
            results_seen++;
            if (want_kind.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat: expected none, got kind %0d byte 0x%02h",
                         $time, kind, value);
            end else begin
                exp_kind = want_kind.pop_front();
                exp_byte = want_byte.pop_front();
                if (kind != exp_kind) begin
                    errors++;
                    $display("%0t: result_kind mismatch: expected %0d, got %0d",
                             $time, exp_kind, kind);
                end
                if (value != exp_byte) begin
                    errors++;
                    $display("%0t: out_byte mismatch: expected 0x%02h, got 0x%02h",
                             $time, exp_byte, value);
                end
            end
        endfunction
    endclass

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_cfg_wr_en    = 1'b0;
    logic [3:0] i_cfg_wr_data  = lse_pkg::BITS_RESET;
    logic       s_axis_tvalid  = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata   = '0;     // [7:0] data_byte
    logic [1:0] s_axis_tuser   = '0;     // [1:0] operation
    logic       m_axis_tvalid;
    logic       m_axis_tready  = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic [1:0] m_axis_tuser;            // [1:0] result_kind

    stego_scoreboard sb = new();

    bit tx_idle   = 1'b1;
    bit rx_idle   = 1'b1;
    bit hold_req  = 1'b0;
    int idle_cycles = 0;
    int cfg_writes  = 0;

    lsb_stego_embed_unit #(
        .MESSAGE_BUFFER_BITS(BUF_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: random stalls per beat while rx_idle is set, plus one long hold-off on request.
    initial begin
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            gap = rx_idle ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
                $display("tb_lsb_stego_embed_unit: FAIL");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic [1:0] op, input logic [7:0] data);
        int gap;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge i_clk);
        sb.note_input(op, data);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        // A message or end beat gives no result but may still be in flight.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bits(input logic [3:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_bits(value);
        cfg_writes++;
    endtask

    // Message share roughly matches what the covers consume, so the buffer
    // moves between empty and full rather than sticking at either end.
    task automatic random_beats(input int count, input bit with_hold);
        int         msg_pct;
        int         r;
        logic [1:0] op;
        msg_pct = (100 * sb.eff_bits()) / (sb.eff_bits() + 8);
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == 40) begin
                hold_req = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 4) begin
                op = OP_RESERVED;
            end else if (r < 4 + msg_pct + $urandom_range(0, 20) - 10) begin
                op = lse_pkg::OP_MESSAGE;
            end else begin
                op = lse_pkg::OP_COVER;
            end
            send_beat(op, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [3:0] settings [NUM_PHASES];
        settings = '{4'd0, 4'd2, 4'd5, 4'd8, 4'd15, 4'd1, 4'd4, 4'd9, 4'd7, 4'd3, 4'd6, 4'd0};
        settings[NUM_PHASES - 1] = 4'($urandom_range(0, 15));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting of one bit: underruns, a full buffer, an overflow, noise.
        send_beat(lse_pkg::OP_COVER, 8'hFF);
        send_beat(lse_pkg::OP_COVER, 8'h00);
        send_beat(lse_pkg::OP_MESSAGE, 8'h00);
        send_beat(lse_pkg::OP_MESSAGE, 8'hFF);
        send_beat(lse_pkg::OP_MESSAGE, 8'hA5);
        send_beat(OP_RESERVED, 8'h5A);
        send_beat(lse_pkg::OP_COVER, 8'hFF);
        send_beat(lse_pkg::OP_COVER, 8'h00);
        send_beat(lse_pkg::OP_COVER, 8'hFF);
        send_beat(lse_pkg::OP_COVER, 8'h00);
        wait_drained();
        write_bits(lse_pkg::BITS_MAX);
        send_beat(lse_pkg::OP_COVER, 8'hAA);
        send_beat(lse_pkg::OP_COVER, 8'h55);
        send_beat(lse_pkg::OP_MESSAGE, 8'h81);
        send_beat(lse_pkg::OP_COVER, 8'h3C);
        send_beat(lse_pkg::OP_COVER, 8'hC3);
        wait_drained();
        write_bits(4'd15);
        send_beat(lse_pkg::OP_COVER, 8'h00);
        send_beat(lse_pkg::OP_MESSAGE, 8'h7E);
        send_beat(lse_pkg::OP_COVER, 8'hFF);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_bits(settings[p]);
            tx_idle = (p % 4 == 0) || (p % 4 == 2);
            rx_idle = (p % 4 == 0) || (p % 4 == 1);
            random_beats(ITEMS_PER_PHASE, p == 3);
        end

        // Empty the buffer one bit at a time before closing the message.
        wait_drained();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_bits(lse_pkg::BITS_MIN);
        while (sb.msg_count != 0) begin
            send_beat(lse_pkg::OP_COVER, 8'($urandom_range(0, 255)));
        end
        wait_drained();
        write_bits(4'd3);
        send_beat(lse_pkg::OP_MESSAGE, 8'hB6);
        send_beat(lse_pkg::OP_MESSAGE, 8'h00);
        send_beat(lse_pkg::OP_COVER, 8'hFF);
        send_beat(lse_pkg::OP_COVER, 8'h00);
        send_beat(lse_pkg::OP_END, 8'h00);
        send_beat(lse_pkg::OP_END, 8'hFF);
        // Whole chunks still embed after the end; the last one is padded.
        send_beat(lse_pkg::OP_COVER, 8'hFF);
        send_beat(lse_pkg::OP_COVER, 8'h00);
        send_beat(lse_pkg::OP_COVER, 8'hFF);
        send_beat(lse_pkg::OP_COVER, 8'hFF);
        send_beat(lse_pkg::OP_COVER, 8'h81);
        send_beat(lse_pkg::OP_MESSAGE, 8'h3C);
        send_beat(OP_RESERVED, 8'hC3);
        for (int i = 0; i < 100; i++) begin
            send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d input beats and %0d result beats over %0d bit settings,",
                 sb.inputs_seen, sb.results_seen, cfg_writes);
        $display("with overflow, underrun, a long output stall and end-of-message padding.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_lsb_stego_embed_unit: PASS");
        end else begin
            $display("tb_lsb_stego_embed_unit: FAIL");
        end
        $finish;
    end

endmodule
